// ----- hw/rtl/psh_pkg.sv -----
// Package for the pair separation histogram: sizes, opcodes, register indexes.
// No dependencies; used by every module of the block.
`default_nettype none
package psh_pkg;
  localparam int MaxBins   = 64;
  localparam int BinBits   = $clog2(MaxBins);
  localparam int EdgeDepth = MaxBins + 1;
  localparam int SlotBits  = 7;
  localparam int EdgeBits  = 58;
  localparam int PosBits   = 28;
  localparam int CountBits = 48;
  localparam int SumBits   = 64;
  localparam int WBits     = 16;
  localparam int CfgBits   = 28;
  localparam int R2Bits    = 60;
  localparam int RootBits  = 30;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_PAIR  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  localparam logic [2:0] REG_NUM_EDGES = 3'd0;
  localparam logic [2:0] REG_RAVG      = 3'd1;
  localparam logic [2:0] REG_WAVG      = 3'd2;
  localparam logic [2:0] REG_WMODE     = 3'd3;
  localparam logic [2:0] REG_WRAP_X    = 3'd4;
  localparam logic [2:0] REG_WRAP_Y    = 3'd5;
  localparam logic [2:0] REG_WRAP_Z    = 3'd6;

  // Accumulator entry of one bin.
  typedef struct packed {
    logic [CountBits-1:0] count;
    logic [SumBits-1:0]   sep;
    logic [SumBits-1:0]   wsum;
  } acc_t;
endpackage
`default_nettype wire

// ----- hw/rtl/psh_sqrt.sv -----
// Bit-serial integer square root of the squared separation, two bits per cycle.
// Depends on psh_pkg.
`default_nettype none
module psh_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          go,
  input  wire logic [psh_pkg::R2Bits-1:0]    radicand,
  output logic                               done,
  output logic [psh_pkg::RootBits-1:0]       root
);
  import psh_pkg::*;

  localparam int Steps = R2Bits / 2;

  logic [R2Bits-1:0]         rem;
  logic [R2Bits-1:0]         src;
  logic [RootBits-1:0]       acc;
  logic [$clog2(Steps+1)-1:0] cnt;
  logic                      run;
  logic [R2Bits+1:0]         trial;
  logic [R2Bits+1:0]         shifted;

  // Bring down the next two bits and try the next root bit.
  always_comb begin
    shifted = {rem, src[R2Bits-1 -: 2]};
    trial   = {{(R2Bits-RootBits){1'b0}}, acc, 2'b01};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
    end else if (go) begin
      run <= 1'b1;
      rem <= '0;
      src <= radicand;
      acc <= '0;
      cnt <= Steps[$clog2(Steps+1)-1:0];
    end else if (run) begin
      src <= src << 2;
      if (shifted >= trial) begin
        rem <= R2Bits'(shifted - trial);
        acc <= {acc[RootBits-2:0], 1'b1};
      end else begin
        rem <= R2Bits'(shifted);
        acc <= {acc[RootBits-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == 1) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign root = acc;
endmodule
`default_nettype wire

// ----- hw/rtl/psh_ctrl.sv -----
// Sequencer: separation, edge search over the edge memory, read-modify-write
// of the accumulator memory, bin readout, clearing pass. Depends on psh_pkg and psh_sqrt.
`default_nettype none
module psh_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    opcode,
  input  wire logic [psh_pkg::SlotBits-1:0]  slot,
  input  wire logic [psh_pkg::EdgeBits-1:0]  edge_value,
  input  wire logic [psh_pkg::PosBits-1:0]   primary_x,
  input  wire logic [psh_pkg::PosBits-1:0]   primary_y,
  input  wire logic [psh_pkg::PosBits-1:0]   primary_z,
  input  wire logic [psh_pkg::WBits-1:0]     primary_weight,
  input  wire logic [psh_pkg::PosBits-1:0]   secondary_x,
  input  wire logic [psh_pkg::PosBits-1:0]   secondary_y,
  input  wire logic [psh_pkg::PosBits-1:0]   secondary_z,
  input  wire logic [psh_pkg::WBits-1:0]     secondary_weight,
  input  wire logic [6:0]                    num_edges,
  input  wire logic                          ravg_enable,
  input  wire logic                          wavg_enable,
  input  wire logic                          weight_mode,
  input  wire logic [psh_pkg::PosBits-1:0]   wrap_x,
  input  wire logic [psh_pkg::PosBits-1:0]   wrap_y,
  input  wire logic [psh_pkg::PosBits-1:0]   wrap_z,
  output logic                               done,
  output logic                               pair_counted,
  output logic [5:0]                         pair_bin,
  output logic [psh_pkg::CountBits-1:0]      bin_total,
  output logic [psh_pkg::SumBits-1:0]        bin_sep_sum,
  output logic [psh_pkg::SumBits-1:0]        bin_weight_sum
);
  import psh_pkg::*;

  localparam int EIdx = $clog2(EdgeDepth);
  localparam int DBits = PosBits + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_SQ, S_SUM, S_HI, S_CHK, S_SRCH, S_ROOT,
    S_RD, S_WR, S_READ, S_RBIN, S_CLR
  } state_t;

  state_t state;

  // Memories
  logic [EdgeBits-1:0] edge_mem [EdgeDepth];
  acc_t                acc_mem  [MaxBins];
  logic [EdgeBits-1:0] edge_q;
  logic [EIdx-1:0]     edge_ra;
  acc_t                acc_q;
  logic [BinBits-1:0]  acc_ra;
  logic                acc_we;
  logic [BinBits-1:0]  acc_wa;
  acc_t                acc_wd;

  // Item registers
  op_t                 op;
  logic [SlotBits-1:0] slot_r;
  logic [PosBits-1:0]  px, py, pz, sx, sy, sz;
  logic [WBits-1:0]    pw, sw;
  logic signed [DBits-1:0] dx, dy, dz;
  logic [R2Bits-1:0]   qx, qy, qz, r2;
  logic [31:0]         wprod;
  logic [EIdx-1:0]     k;
  logic [EIdx-1:0]     ne;
  logic [EdgeBits-1:0] edge0;
  logic                sq_go, sq_done;
  logic [RootBits-1:0] root;
  logic                root_ok;
  logic [BinBits:0]    clr_cnt;

  logic [DBits-1:0] mx, my, mz;
  logic [R2Bits-1:0] sqx, sqy, sqz;
  logic [SumBits:0] sep_add, w_add;
  logic [CountBits-1:0] cnt_inc;
  logic [CountBits-1:0] rd_cnt;
  logic [SumBits-1:0]   rd_sep, rd_w;

  always_comb begin
    mx = dx[DBits-1] ? DBits'(-dx) : DBits'(dx);
    my = dy[DBits-1] ? DBits'(-dy) : DBits'(dy);
    mz = dz[DBits-1] ? DBits'(-dz) : DBits'(dz);
    sqx = mx * mx;
    sqy = my * my;
    sqz = mz * mz;
    sep_add = {1'b0, acc_q.sep} + {{(SumBits+1-RootBits){1'b0}}, root};
    w_add   = {1'b0, acc_q.wsum} + {{(SumBits-31){1'b0}}, wprod};
    cnt_inc = (acc_q.count == '1) ? acc_q.count : acc_q.count + 1'b1;
  end

  // Zero a read of a slot past the last bin.
  always_comb begin
    rd_cnt = '0; rd_sep = '0; rd_w = '0;
    if (slot_r < SlotBits'(MaxBins)) begin
      rd_cnt = acc_q.count; rd_sep = acc_q.sep; rd_w = acc_q.wsum;
    end
  end

  // Edge memory: one write, one registered read.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start && opcode == OP_LOAD && slot <= SlotBits'(MaxBins))
      edge_mem[slot[EIdx-1:0]] <= edge_value;
    edge_q <= edge_mem[edge_ra];
  end

  // Accumulator memory: one write, one registered read.
  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_wa] <= acc_wd;
    acc_q <= acc_mem[acc_ra];
  end

  psh_sqrt u_sqrt (
    .clk(clk), .rst(rst), .go(sq_go), .radicand(r2), .done(sq_done), .root(root)
  );

  assign busy = (state != S_IDLE);

  // Sequencer and registered results.
  always_ff @(posedge clk) begin
    done   <= 1'b0;
    sq_go  <= 1'b0;
    acc_we <= 1'b0;
    if (rst) begin
      state   <= S_CLR;
      clr_cnt <= '0;
      op      <= OP_LOAD;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            op     <= op_t'(opcode);
            slot_r <= slot;
            px <= primary_x; py <= primary_y; pz <= primary_z;
            sx <= secondary_x; sy <= secondary_y; sz <= secondary_z;
            pw <= primary_weight; sw <= secondary_weight;
            pair_counted   <= 1'b0;
            pair_bin       <= '0;
            bin_total      <= '0;
            bin_sep_sum    <= '0;
            bin_weight_sum <= '0;
            if (num_edges < 7'd2) ne <= EIdx'(2);
            else if (num_edges > 7'(EdgeDepth)) ne <= EIdx'(EdgeDepth);
            else ne <= num_edges[EIdx-1:0];
            case (opcode)
              OP_CLEAR: begin
                clr_cnt <= '0;
                state   <= S_CLR;
              end
              OP_LOAD: begin
                done <= 1'b1;
              end
              OP_PAIR: state <= S_DIFF;
              default: begin
                acc_ra <= slot[BinBits-1:0];
                state  <= S_READ;
              end
            endcase
          end
        end
        S_DIFF: begin
          dx <= $signed({{2{sx[PosBits-1]}}, sx})
              - $signed({{2{px[PosBits-1]}}, px}) - $signed({{2{wrap_x[PosBits-1]}}, wrap_x});
          dy <= $signed({{2{sy[PosBits-1]}}, sy})
              - $signed({{2{py[PosBits-1]}}, py}) - $signed({{2{wrap_y[PosBits-1]}}, wrap_y});
          dz <= $signed({{2{sz[PosBits-1]}}, sz})
              - $signed({{2{pz[PosBits-1]}}, pz}) - $signed({{2{wrap_z[PosBits-1]}}, wrap_z});
          wprod <= weight_mode ? pw * sw : 32'd0;
          edge_ra <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          qx <= sqx;
          qy <= sqy;
          qz <= sqz;
          edge_ra <= ne - 1'b1;
          state <= S_SUM;
        end
        S_SUM: begin
          // First edge lands here, in the cycle after its address.
          edge0 <= edge_q;
          r2 <= qx + qy + qz;
          state <= S_HI;
        end
        S_HI: begin
          // Range check against first and last edge in use.
          if ({2'b0, edge0} <= r2 && {2'b0, edge_q} > r2) begin
            k <= ne - 2'd2;
            edge_ra <= ne - 2'd2;
            sq_go <= 1'b1;
            root_ok <= 1'b0;
            state <= S_CHK;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_CHK: state <= S_SRCH;
        // Walk down the edges, one per pass through S_CHK and S_SRCH, until r2 reaches one or k is zero.
        S_SRCH: begin
          if (k != '0 && r2 < {2'b0, edge_q}) begin
            k <= k - 1'b1;
            edge_ra <= k - 1'b1;
            state <= S_CHK;
          end else begin
            acc_ra <= k[BinBits-1:0];
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (sq_done || root_ok) state <= S_RD;
        end
        S_RD: state <= S_WR;
        S_WR: begin
          acc_we <= 1'b1;
          acc_wa <= k[BinBits-1:0];
          acc_wd.count <= cnt_inc;
          acc_wd.sep  <= !ravg_enable ? acc_q.sep :
                         (sep_add[SumBits] ? '1 : sep_add[SumBits-1:0]);
          acc_wd.wsum <= !wavg_enable ? acc_q.wsum :
                         (w_add[SumBits] ? '1 : w_add[SumBits-1:0]);
          pair_counted <= 1'b1;
          pair_bin     <= 6'(k);
          done  <= 1'b1;
          state <= S_IDLE;
        end
        // Wait for the registered read of the bin.
        S_READ: state <= S_RBIN;
        S_RBIN: begin
          bin_total      <= rd_cnt;
          bin_sep_sum    <= rd_sep;
          bin_weight_sum <= rd_w;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_CLR: begin
          acc_we <= 1'b1;
          acc_wa <= clr_cnt[BinBits-1:0];
          acc_wd <= '0;
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (BinBits+1)'(MaxBins - 1)) begin
            done  <= (op == OP_CLEAR);
            op    <= OP_LOAD;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // Remember a root that finishes while the edge walk is still running.
      if (sq_done) root_ok <= 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    acc_we |-> state != S_IDLE || $past(state) == S_WR || $past(state) == S_CLR)
    else $error("accumulator write outside update or clear");
  assert property (@(posedge clk) disable iff (rst) sq_go |-> state == S_CHK)
    else $error("root started outside edge search");
  assert property (@(posedge clk) disable iff (rst) (state == S_SRCH) |-> k < ne)
    else $error("edge search index past edges in use");
endmodule
`default_nettype wire

// ----- hw/rtl/pair_separation_histogram_core.sv -----
// Top level of the pair separation histogram: configuration registers and
// result strobe. Depends on psh_pkg and psh_ctrl.
// A pair out of range of the edges in use ends after the range check; one in range
// walks the edges one at a time beside the 30-step root, then updates its bin.
// Throughput: one item at a time; busy is high while a pair, read or clear is in work.
// Reset runs the clearing sweep over all 64 bins with busy high. The receiver cannot stall.
`default_nettype none
module pair_separation_histogram_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          cfg_we,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [psh_pkg::CfgBits-1:0]   cfg_data,
  input  wire logic [1:0]                    opcode,
  input  wire logic [psh_pkg::SlotBits-1:0]  slot,
  input  wire logic [psh_pkg::EdgeBits-1:0]  edge_value,
  input  wire logic [psh_pkg::PosBits-1:0]   primary_x,
  input  wire logic [psh_pkg::PosBits-1:0]   primary_y,
  input  wire logic [psh_pkg::PosBits-1:0]   primary_z,
  input  wire logic [psh_pkg::WBits-1:0]     primary_weight,
  input  wire logic [psh_pkg::PosBits-1:0]   secondary_x,
  input  wire logic [psh_pkg::PosBits-1:0]   secondary_y,
  input  wire logic [psh_pkg::PosBits-1:0]   secondary_z,
  input  wire logic [psh_pkg::WBits-1:0]     secondary_weight,
  output logic                               done,
  output logic                               pair_counted,
  output logic [5:0]                         pair_bin,
  output logic [psh_pkg::CountBits-1:0]      bin_total,
  output logic [psh_pkg::SumBits-1:0]        bin_sep_sum,
  output logic [psh_pkg::SumBits-1:0]        bin_weight_sum
);
  import psh_pkg::*;

  logic [6:0]         num_edges;
  logic               ravg_enable, wavg_enable, weight_mode;
  logic [PosBits-1:0] wrap_x, wrap_y, wrap_z;

  // Hold configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_edges <= 7'd2; ravg_enable <= 1'b0; wavg_enable <= 1'b0;
      weight_mode <= 1'b0; wrap_x <= '0; wrap_y <= '0; wrap_z <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_EDGES: num_edges   <= cfg_data[6:0];
        REG_RAVG:      ravg_enable <= cfg_data[0];
        REG_WAVG:      wavg_enable <= cfg_data[0];
        REG_WMODE:     weight_mode <= cfg_data[0];
        REG_WRAP_X:    wrap_x      <= cfg_data[PosBits-1:0];
        REG_WRAP_Y:    wrap_y      <= cfg_data[PosBits-1:0];
        REG_WRAP_Z:    wrap_z      <= cfg_data[PosBits-1:0];
        default: ;
      endcase
    end
  end

  psh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .slot(slot), .edge_value(edge_value),
    .primary_x(primary_x), .primary_y(primary_y), .primary_z(primary_z),
    .primary_weight(primary_weight),
    .secondary_x(secondary_x), .secondary_y(secondary_y), .secondary_z(secondary_z),
    .secondary_weight(secondary_weight),
    .num_edges(num_edges), .ravg_enable(ravg_enable), .wavg_enable(wavg_enable),
    .weight_mode(weight_mode), .wrap_x(wrap_x), .wrap_y(wrap_y), .wrap_z(wrap_z),
    .done(done), .pair_counted(pair_counted), .pair_bin(pair_bin),
    .bin_total(bin_total), .bin_sep_sum(bin_sep_sum), .bin_weight_sum(bin_weight_sum)
  );
endmodule
`default_nettype wire
